>>> sv/permission_mode_string_parser_assert.svh
// Assertion macros used by the checker file of the mode string parser.
`ifndef PERMISSION_MODE_STRING_PARSER_ASSERT_SVH
`define PERMISSION_MODE_STRING_PARSER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PMSP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define PMSP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/pmsp_pkg.sv
// ----------------------------------------------------------------------------
// pmsp_pkg
// Types and constants of the permission mode string parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pmsp_pkg;

    localparam logic [11:0] MODE_MASK  = 12'o7777;
    localparam logic [11:0] MASK_USER  = 12'o4700;
    localparam logic [11:0] MASK_GROUP = 12'o2070;
    localparam logic [11:0] MASK_OTHER = 12'o1007;
    localparam logic [11:0] BITS_SUID  = 12'o6000;
    localparam logic [11:0] BITS_READ  = 12'o0444;
    localparam logic [11:0] BITS_WRITE = 12'o0222;
    localparam logic [11:0] BITS_EXEC  = 12'o0111;
    localparam logic [11:0] BITS_STICKY = 12'o1000;
    localparam logic [11:0] UMASK_RESET = 12'o0022;

    localparam logic [1:0] OP_NONE = 2'd0;
    localparam logic [1:0] OP_ADD  = 2'd1;
    localparam logic [1:0] OP_SUB  = 2'd2;
    localparam logic [1:0] OP_SET  = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_SYNTAX = 2'd1;
    localparam logic [1:0] ST_RANGE  = 2'd2;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_PLUS  = "+";
    localparam logic [7:0] CH_MINUS = "-";
    localparam logic [7:0] CH_EQ    = "=";
    localparam logic [7:0] CH_COMMA = ",";
    localparam logic [7:0] CH_U     = "u";
    localparam logic [7:0] CH_G     = "g";
    localparam logic [7:0] CH_O     = "o";
    localparam logic [7:0] CH_A     = "a";
    localparam logic [7:0] CH_R     = "r";
    localparam logic [7:0] CH_W     = "w";
    localparam logic [7:0] CH_X     = "x";
    localparam logic [7:0] CH_BIG_X = "X";
    localparam logic [7:0] CH_S     = "s";
    localparam logic [7:0] CH_T     = "t";

    typedef enum logic [2:0] {
        PH_START  = 3'd0,
        PH_SIGN   = 3'd1,
        PH_OCTAL  = 3'd2,
        PH_WHO    = 3'd3,
        PH_OPER   = 3'd4,
        PH_PERM   = 3'd5,
        PH_COPIED = 3'd6,
        PH_DONE   = 3'd7
    } t_phase;

    typedef struct packed {
        logic [11:0] orig_mode;
        logic [11:0] work_mode;
        logic [11:0] clause_mask;
        logic [11:0] perm_bits;
        logic [1:0]  pending_op;
        t_phase      phase;
        logic [1:0]  clause_len;
        logic [11:0] octal_accum;
        logic [1:0]  numeric_kind;
        logic [1:0]  error_code;
        logic        dir_latched;
    } t_pstate;

    typedef struct packed {
        logic [7:0]  ch;
        logic        first;
        logic        last;
        logic [11:0] start_mode;
        logic        is_dir;
    } t_item;

    typedef struct packed {
        logic [11:0] new_mode;
        logic [1:0]  status;
    } t_result;

endpackage

`default_nettype wire

>>> sv/pmsp_in_stage.sv
// ----------------------------------------------------------------------------
// pmsp_in_stage
// Input register: holds one character transaction until the parser takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pmsp_in_stage (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire pmsp_pkg::t_item i_item,
    input  wire logic           i_take,
    output logic                o_valid,
    output pmsp_pkg::t_item     o_item
);

    logic            r_valid;
    pmsp_pkg::t_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

`default_nettype wire

>>> sv/pmsp_step.sv
// ----------------------------------------------------------------------------
// pmsp_step
// Parse state and umask registers; a character per cycle unless stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pmsp_step (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cfg_we,
    input  wire logic [11:0]     i_cfg_data,
    input  wire logic            i_item_valid,
    input  wire pmsp_pkg::t_item i_item,
    input  wire logic            i_out_free,
    output logic                 o_take,
    output logic                 o_res_valid,
    output pmsp_pkg::t_result    o_res
);

    logic [11:0]       r_umask;
    pmsp_pkg::t_pstate r_state;
    pmsp_pkg::t_pstate n_state;
    logic [1:0]        op;

    function automatic logic [1:0] f_op_code(input logic [7:0] c);
        logic [1:0] r;
        r = pmsp_pkg::OP_NONE;
        if (c == pmsp_pkg::CH_PLUS) r = pmsp_pkg::OP_ADD;
        else if (c == pmsp_pkg::CH_MINUS) r = pmsp_pkg::OP_SUB;
        else if (c == pmsp_pkg::CH_EQ) r = pmsp_pkg::OP_SET;
        return r;
    endfunction

    function automatic logic f_is_octal(input logic [7:0] c);
        return c[7:3] == 5'b00110;
    endfunction

    function automatic pmsp_pkg::t_pstate f_fail(input pmsp_pkg::t_pstate s);
        pmsp_pkg::t_pstate r;
        r = s;
        r.error_code = pmsp_pkg::ST_SYNTAX;
        r.phase = pmsp_pkg::PH_DONE;
        return r;
    endfunction

    function automatic pmsp_pkg::t_pstate f_bump(input pmsp_pkg::t_pstate s);
        pmsp_pkg::t_pstate r;
        r = s;
        if (r.clause_len < 2'd2) r.clause_len = r.clause_len + 2'd1;
        return r;
    endfunction

    function automatic pmsp_pkg::t_pstate f_apply_op(input pmsp_pkg::t_pstate s);
        pmsp_pkg::t_pstate r;
        logic [11:0] b;
        logic [11:0] keep;
        r = s;
        b = s.perm_bits & s.clause_mask;
        keep = s.dir_latched ? (s.work_mode & pmsp_pkg::BITS_SUID) : 12'd0;
        case (s.pending_op)
            pmsp_pkg::OP_ADD: r.work_mode = s.work_mode | b;
            pmsp_pkg::OP_SUB: r.work_mode = s.work_mode & ~b;
            pmsp_pkg::OP_SET: r.work_mode = (s.work_mode & ~s.clause_mask) | b | keep;
            default: r.work_mode = s.work_mode;
        endcase
        return r;
    endfunction

    function automatic pmsp_pkg::t_pstate f_end_clause(input pmsp_pkg::t_pstate s);
        pmsp_pkg::t_pstate r;
        logic bad;
        r = s;
        if (s.phase == pmsp_pkg::PH_WHO) bad = (s.clause_len != 2'd0);
        else bad = (s.clause_len < 2'd2);
        if (bad) begin
            r = f_fail(s);
        end else begin
            if (s.phase != pmsp_pkg::PH_WHO) r = f_apply_op(r);
            r.clause_len  = 2'd0;
            r.clause_mask = 12'd0;
            r.perm_bits   = 12'd0;
            r.pending_op  = pmsp_pkg::OP_NONE;
            r.phase       = pmsp_pkg::PH_WHO;
        end
        return r;
    endfunction

    function automatic pmsp_pkg::t_pstate f_begin_op(input pmsp_pkg::t_pstate s,
                                                     input logic [1:0] op_in,
                                                     input logic [11:0] umask);
        pmsp_pkg::t_pstate r;
        r = s;
        if (s.clause_len == 2'd0) r.clause_mask = pmsp_pkg::MODE_MASK & ~umask;
        r.pending_op = op_in;
        r.perm_bits  = 12'd0;
        r = f_bump(r);
        r.phase = pmsp_pkg::PH_OPER;
        return r;
    endfunction

    function automatic pmsp_pkg::t_pstate f_commit(input pmsp_pkg::t_pstate s);
        pmsp_pkg::t_pstate r;
        logic [11:0] keep;
        r = s;
        keep = s.dir_latched ? (s.orig_mode & pmsp_pkg::BITS_SUID) : 12'd0;
        if (s.error_code == pmsp_pkg::ST_OK) begin
            case (s.numeric_kind)
                pmsp_pkg::OP_ADD: r.work_mode = s.work_mode | s.octal_accum;
                pmsp_pkg::OP_SUB: r.work_mode = s.work_mode & ~s.octal_accum;
                pmsp_pkg::OP_SET: r.work_mode = s.octal_accum;
                default: r.work_mode = s.octal_accum | keep;
            endcase
        end
        r.phase = pmsp_pkg::PH_DONE;
        return r;
    endfunction

    function automatic pmsp_pkg::t_pstate f_symbolic(input pmsp_pkg::t_pstate s,
                                                     input logic [7:0] c,
                                                     input logic [11:0] umask);
        pmsp_pkg::t_pstate r;
        logic [1:0]  sop;
        logic [2:0]  v;
        logic        hit;
        logic [11:0] bits;
        r = s;
        sop = f_op_code(c);
        v = 3'd0;
        hit = 1'b1;
        bits = 12'd0;
        if (c == pmsp_pkg::CH_COMMA) begin
            r = f_end_clause(s);
        end else if (s.phase == pmsp_pkg::PH_WHO) begin
            if (c == pmsp_pkg::CH_U) begin
                r.clause_mask = s.clause_mask | pmsp_pkg::MASK_USER;
                r = f_bump(r);
            end else if (c == pmsp_pkg::CH_G) begin
                r.clause_mask = s.clause_mask | pmsp_pkg::MASK_GROUP;
                r = f_bump(r);
            end else if (c == pmsp_pkg::CH_O) begin
                r.clause_mask = s.clause_mask | pmsp_pkg::MASK_OTHER;
                r = f_bump(r);
            end else if (c == pmsp_pkg::CH_A) begin
                r.clause_mask = pmsp_pkg::MODE_MASK;
                r = f_bump(r);
            end else if (sop != pmsp_pkg::OP_NONE) begin
                r = f_begin_op(s, sop, umask);
            end else begin
                r = f_fail(s);
            end
        end else if (sop != pmsp_pkg::OP_NONE) begin
            r = f_begin_op(f_apply_op(s), sop, umask);
        end else begin
            r = f_bump(s);
            if (s.phase == pmsp_pkg::PH_OPER &&
                (c == pmsp_pkg::CH_U || c == pmsp_pkg::CH_G || c == pmsp_pkg::CH_O)) begin
                if (c == pmsp_pkg::CH_U) v = s.work_mode[8:6];
                else if (c == pmsp_pkg::CH_G) v = s.work_mode[5:3];
                else v = s.work_mode[2:0];
                r.perm_bits = {3'd0, v, v, v};
                r.phase = pmsp_pkg::PH_COPIED;
            end else begin
                case (c)
                    pmsp_pkg::CH_R: bits = pmsp_pkg::BITS_READ;
                    pmsp_pkg::CH_W: bits = pmsp_pkg::BITS_WRITE;
                    pmsp_pkg::CH_X: bits = pmsp_pkg::BITS_EXEC;
                    pmsp_pkg::CH_S: bits = pmsp_pkg::BITS_SUID;
                    pmsp_pkg::CH_T: bits = pmsp_pkg::BITS_STICKY;
                    pmsp_pkg::CH_BIG_X: begin
                        if (s.dir_latched || s.work_mode[6] || s.work_mode[3] ||
                            s.work_mode[0]) begin
                            bits = pmsp_pkg::BITS_EXEC;
                        end
                    end
                    default: hit = 1'b0;
                endcase
                if (hit && (s.phase == pmsp_pkg::PH_OPER || s.phase == pmsp_pkg::PH_PERM)) begin
                    r.perm_bits = r.perm_bits | bits;
                    r.phase = pmsp_pkg::PH_PERM;
                end else begin
                    r = f_fail(r);
                end
            end
        end
        return r;
    endfunction

    assign o_take = i_item_valid && (!i_item.last || i_out_free);
    assign op     = f_op_code(i_item.ch);

    // next state
    always_comb begin
        n_state = r_state;
        if (i_item.first || r_state.phase == pmsp_pkg::PH_START) begin
            n_state.orig_mode    = i_item.start_mode;
            n_state.work_mode    = i_item.start_mode;
            n_state.dir_latched  = i_item.is_dir;
            n_state.clause_mask  = 12'd0;
            n_state.perm_bits    = 12'd0;
            n_state.pending_op   = pmsp_pkg::OP_NONE;
            n_state.clause_len   = 2'd0;
            n_state.octal_accum  = 12'd0;
            n_state.numeric_kind = pmsp_pkg::OP_NONE;
            n_state.error_code   = pmsp_pkg::ST_OK;
            if (i_item.ch == pmsp_pkg::CH_NUL) begin
                n_state.phase = pmsp_pkg::PH_DONE;
            end else if (op != pmsp_pkg::OP_NONE) begin
                n_state.numeric_kind = op;
                n_state = f_begin_op(n_state, op, r_umask);
                n_state.phase = pmsp_pkg::PH_SIGN;
            end else if (f_is_octal(i_item.ch)) begin
                n_state.octal_accum = {9'd0, i_item.ch[2:0]};
                n_state.phase = pmsp_pkg::PH_OCTAL;
            end else begin
                n_state.phase = pmsp_pkg::PH_WHO;
                n_state = f_symbolic(n_state, i_item.ch, r_umask);
            end
        end else begin
            unique case (r_state.phase)
                pmsp_pkg::PH_SIGN: begin
                    if (f_is_octal(i_item.ch)) begin
                        n_state.octal_accum = {9'd0, i_item.ch[2:0]};
                        n_state.phase = pmsp_pkg::PH_OCTAL;
                    end else if (i_item.ch == pmsp_pkg::CH_NUL) begin
                        n_state = f_end_clause(r_state);
                        n_state.phase = pmsp_pkg::PH_DONE;
                    end else begin
                        n_state.phase = pmsp_pkg::PH_OPER;
                        n_state = f_symbolic(n_state, i_item.ch, r_umask);
                    end
                end
                pmsp_pkg::PH_OCTAL: begin
                    if (f_is_octal(i_item.ch)) begin
                        if (r_state.octal_accum[11:9] != 3'd0) begin
                            n_state.error_code = pmsp_pkg::ST_RANGE;
                        end else begin
                            n_state.octal_accum = {r_state.octal_accum[8:0], i_item.ch[2:0]};
                        end
                    end else begin
                        n_state = f_commit(r_state);
                    end
                end
                pmsp_pkg::PH_DONE: begin
                    n_state = r_state;
                end
                default: begin
                    if (i_item.ch == pmsp_pkg::CH_NUL) begin
                        n_state = f_end_clause(r_state);
                        n_state.phase = pmsp_pkg::PH_DONE;
                    end else begin
                        n_state = f_symbolic(r_state, i_item.ch, r_umask);
                    end
                end
            endcase
        end
        if (i_item.last) begin
            if (n_state.phase == pmsp_pkg::PH_OCTAL) begin
                n_state = f_commit(n_state);
            end else if (n_state.phase != pmsp_pkg::PH_DONE) begin
                n_state = f_end_clause(n_state);
            end
            n_state.phase = pmsp_pkg::PH_START;
        end
    end

    // outputs
    always_comb begin
        o_res_valid     = o_take && i_item.last;
        o_res.status    = n_state.error_code;
        o_res.new_mode  = (n_state.error_code != pmsp_pkg::ST_OK) ? 12'd0 : n_state.work_mode;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_umask <= pmsp_pkg::UMASK_RESET;
        end else if (i_cfg_we) begin
            r_umask <= i_cfg_data;
        end
    end

    // all-zero state is the start-of-string phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (o_take) begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

>>> sv/pmsp_out_stage.sv
// ----------------------------------------------------------------------------
// pmsp_out_stage
// Result register: holds the mode and status until the result is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pmsp_out_stage (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_res_valid,
    input  wire pmsp_pkg::t_result i_res,
    output logic                   o_free,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output pmsp_pkg::t_result      o_res
);

    logic              r_valid;
    pmsp_pkg::t_result r_res;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_res_valid) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_res_valid) begin
            r_res <= i_res;
        end
    end

endmodule

`default_nettype wire

>>> sv/permission_mode_string_parser.sv
// ----------------------------------------------------------------------------
// permission_mode_string_parser
// Octal and symbolic mode string parser, a character a cycle unless stalled.
// ----------------------------------------------------------------------------
// Takes one character transaction per cycle while no last character waits on
// a stalled result. Each character is held in an input register, then
// updates the parse state register; that state register loop sets the rate.
// The result for a string is loaded into the result register at the edge
// where its last character leaves the input register and is offered until
// taken. A stalled result holds back a following last character and the
// input behind it; earlier characters keep flowing. The user must write umask
// through i_cfg_we / i_cfg_data while idle; the block does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

module permission_mode_string_parser (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [11:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_ch,
    input  wire logic        i_first,
    input  wire logic        i_last,
    input  wire logic [11:0] i_start_mode,
    input  wire logic        i_is_dir,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [11:0]      o_new_mode,
    output logic [1:0]       o_status
);

    pmsp_pkg::t_item   in_item;
    pmsp_pkg::t_item   stg_item;
    pmsp_pkg::t_result res;
    pmsp_pkg::t_result out_res;
    logic              stg_valid;
    logic              take;
    logic              res_valid;
    logic              out_free;

    assign in_item.ch         = i_ch;
    assign in_item.first      = i_first;
    assign in_item.last       = i_last;
    assign in_item.start_mode = i_start_mode;
    assign in_item.is_dir     = i_is_dir;

    pmsp_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (in_item),
        .i_take  (take),
        .o_valid (stg_valid),
        .o_item  (stg_item)
    );

    pmsp_step u_step (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_item_valid (stg_valid),
        .i_item       (stg_item),
        .i_out_free   (out_free),
        .o_take       (take),
        .o_res_valid  (res_valid),
        .o_res        (res)
    );

    pmsp_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_free      (out_free),
        .o_valid     (o_out_valid),
        .i_ready     (i_out_ready),
        .o_res       (out_res)
    );

    assign o_new_mode = out_res.new_mode;
    assign o_status   = out_res.status;

endmodule

`default_nettype wire

>>> sv/pmsp_checker.sv
// ----------------------------------------------------------------------------
// pmsp_checker
// Port-level checks on the mode string parser, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "permission_mode_string_parser_assert.svh"

module pmsp_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_in_ready,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [11:0] o_new_mode,
    input wire logic [1:0]  o_status
);

    `PMSP_ASSERT_NOW(a_status_code, i_clk, i_rst_n, o_out_valid, o_status != 2'd3, "bad status code")

    `PMSP_ASSERT_NOW(a_err_mode_zero, i_clk, i_rst_n, o_out_valid && o_status != 2'd0, o_new_mode == 12'd0, "mode not cleared on error")

    `PMSP_ASSERT_NOW(a_stall_cause, i_clk, i_rst_n, !o_in_ready, o_out_valid && !i_out_ready, "input stalled without a blocked result")

    `PMSP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_new_mode) && $stable(o_status), "result dropped while stalled")

endmodule

bind permission_mode_string_parser pmsp_checker u_pmsp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_new_mode  (o_new_mode),
    .o_status    (o_status)
);

`default_nettype wire
